[sv/assert_macros.svh]
// Assertion macros used by the queue datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

[sv/qpa_pkg.sv]
// Shared codes and controller/datapath interface types for the positional queue.
`timescale 1ns / 1ps
package qpa_pkg;
   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_REMOVE = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic accept;
      logic shift_rd;
      logic shift_wr;
      logic shift_end;
      logic finish;
   } qpa_cmd_type;

   typedef struct packed {
      logic req_ok;
      logic req_shift;
      logic shift_more;
      logic out_free;
   } qpa_stat_type;
endpackage

[sv/qpa_ctrl.sv]
// Controller state machine that sequences requests and the compacting shift.
`timescale 1ns / 1ps
module qpa_ctrl
   import qpa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  qpa_stat_type stat,
   output qpa_cmd_type  cmd
);
   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_SHIFT_RD = 2'd1;
   localparam logic [1:0] S_SHIFT_WR = 2'd2;
   localparam logic [1:0] S_FINISH   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (stat.req_ok && stat.req_shift) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SHIFT_RD: begin
            if (stat.shift_more) begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end else begin
               cmd.shift_end = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[sv/qpa_dpath.sv]
// Datapath: entry memory, head copy, fill count, shift index and response register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qpa_dpath
   import qpa_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = $clog2(DEPTH),
   parameter int CW         = $clog2(DEPTH + 1)
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  qpa_cmd_type           cmd,
   output qpa_stat_type          stat,
   input  logic [1:0]            action,
   input  logic [DATA_WIDTH-1:0] value,
   input  logic [CW-1:0]         position,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [DATA_WIDTH-1:0] read_value,
   output logic [CW-1:0]         count,
   output logic                  is_empty,
   output logic [1:0]            status
);
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic [DATA_WIDTH-1:0] head_ff;
   logic [DATA_WIDTH-1:0] head_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [AW-1:0]         k_ff;
   logic [AW-1:0]         k_in;
   logic [1:0]            status_ff;
   logic                  use_read_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic [CW-1:0]         rsp_count_ff;
   logic                  rsp_empty_ff;
   logic [1:0]            rsp_status_ff;

   logic [1:0]            code;
   logic                  full;
   logic                  empty;
   logic                  pos_bad;
   logic [CW-1:0]         pos_m1;
   logic [CW-1:0]         k_plus1;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pos_bad = (position == '0) || (position > count_ff);
   assign pos_m1  = position - CW'(1);
   assign k_plus1 = CW'(k_ff) + CW'(1);

   always_comb begin
      case (action)
         ACT_PUSH: code = full ? ST_FULL : ST_OK;
         ACT_POP:  code = empty ? ST_EMPTY : ST_OK;
         default:  code = empty ? ST_EMPTY : (pos_bad ? ST_RANGE : ST_OK);
      endcase
   end

   assign stat.req_ok     = (code == ST_OK);
   assign stat.req_shift  = (action == ACT_POP) || (action == ACT_REMOVE);
   assign stat.shift_more = (k_plus1 < count_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = value;
      mem_re    = 1'b0;
      mem_raddr = pos_m1[AW-1:0];
      head_in   = head_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      if (cmd.accept && (code == ST_OK)) begin
         if (action == ACT_PUSH) begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
            if (empty) begin
               head_in = value;
            end
         end
         if (action == ACT_READ) begin
            mem_re = 1'b1;
         end
         k_in = (action == ACT_REMOVE) ? pos_m1[AW-1:0] : '0;
      end
      if (cmd.shift_rd) begin
         mem_re    = 1'b1;
         mem_raddr = k_plus1[AW-1:0];
      end
      if (cmd.shift_wr) begin
         mem_we    = 1'b1;
         mem_waddr = k_ff;
         mem_wdata = rdata_ff;
         k_in      = k_plus1[AW-1:0];
         if (k_ff == '0) begin
            head_in = rdata_ff;
         end
      end
      if (cmd.shift_end) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      k_ff    <= k_in;
      if (cmd.accept) begin
         status_ff   <= code;
         use_read_ff <= (code == ST_OK) && (action == ACT_READ);
      end
      if (cmd.finish) begin
         rsp_value_ff  <= use_read_ff ? rdata_ff
                                      : ((count_ff != '0) ? head_ff : '0);
         rsp_count_ff  <= count_ff;
         rsp_empty_ff  <= (count_ff == '0);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign read_value = rsp_value_ff;
   assign count      = rsp_count_ff;
   assign is_empty   = rsp_empty_ff;
   assign status     = rsp_status_ff;

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `ASSERT_IMPLIES(a_shift_in_range, clock, reset, cmd.shift_wr, k_plus1 < count_ff)
   `ASSERT_IMPLIES(a_finish_free, clock, reset, cmd.finish, stat.out_free)
   `ASSERT_NEXT(a_push_grows, clock, reset, mem_we && !cmd.shift_wr, count_ff == $past(count_ff) + CW'(1))
endmodule

[sv/queue_with_positional_access_top.sv]
// Top level of the FIFO queue with positional read and remove.
// Push, read and error requests go from acceptance to the finish state, then to the response register.
// Pop and remove first run the memory shift loop over m entries (read then write back one place
// lower), m at most DEPTH-1; the finish state waits while a held response is not yet taken.
// A new request is taken only once the previous one is finished, also while a response waits.
// Synchronous reset empties the queue; entry contents stay undefined until written.
`timescale 1ns / 1ps
module queue_with_positional_access_top
   import qpa_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // Fields from bit 0: value, position, zero padding.
   input  logic [((DATA_WIDTH + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields from bit 0: action.
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // Fields from bit 0: read_value, count, zero padding.
   output logic [((DATA_WIDTH + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // Fields from bit 0: is_empty, status.
   output logic [2:0]           rsp_tuser
);
   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int TDW  = ((DATA_WIDTH + CW + 7) / 8) * 8;
   localparam int PADW = TDW - DATA_WIDTH - CW;

   qpa_cmd_type           cmd;
   qpa_stat_type          stat;
   logic [DATA_WIDTH-1:0] read_value;
   logic [CW-1:0]         count;
   logic                  is_empty;
   logic [1:0]            status;

   qpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   qpa_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW),
      .CW         (CW)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .action     (req_tuser),
      .value      (req_tdata[DATA_WIDTH-1:0]),
      .position   (req_tdata[DATA_WIDTH+CW-1:DATA_WIDTH]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .read_value (read_value),
      .count      (count),
      .is_empty   (is_empty),
      .status     (status)
   );

   if (PADW > 0) begin : g_pad
      assign rsp_tdata = {{PADW{1'b0}}, count, read_value};
   end else begin : g_nopad
      assign rsp_tdata = {count, read_value};
   end
   assign rsp_tuser = {status, is_empty};
endmodule

[dv/tb_queue_with_positional_access_top.sv]
// Self-checking testbench for the positional-access queue top level.
`timescale 1ns / 1ps
module tb_queue_with_positional_access_top
   import qpa_pkg::*;
();

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int PORT_WIDTH  = ((DATA_WIDTH + COUNT_WIDTH + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

   typedef struct {
      logic [DATA_WIDTH-1:0]  read_value;
      logic [COUNT_WIDTH-1:0] count;
      logic                   is_empty;
      logic [1:0]             status;
   } queue_response_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PORT_WIDTH-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = ACT_PUSH;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PORT_WIDTH-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;

   logic signed [DATA_WIDTH-1:0] shadow_entries[$];
   queue_response_type           pending_responses[$];
   int                           error_count = 0;
   int                           send_idle_pct = 0;
   int                           recv_idle_pct = 0;
   int                           hold_left = 0;
   int                           cycle_count = 0;

   queue_with_positional_access_top #(
      .DEPTH     (DEPTH),
      .DATA_WIDTH(DATA_WIDTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_queue_with_positional_access_top failed");
      $finish;
   end

   function automatic queue_response_type queue_outcome(input logic [1:0] action,
                                                        input logic [DATA_WIDTH-1:0] value,
                                                        input logic [COUNT_WIDTH-1:0] position);
      queue_response_type rsp;
      logic               got_read;
      got_read   = 1'b0;
      rsp.status = ST_OK;
      rsp.read_value = '0;
      case (action)
         ACT_PUSH: begin
            if (shadow_entries.size() >= DEPTH) rsp.status = ST_FULL;
            else shadow_entries.push_back(value);
         end
         ACT_POP: begin
            if (shadow_entries.size() == 0) rsp.status = ST_EMPTY;
            else void'(shadow_entries.pop_front());
         end
         default: begin
            if (shadow_entries.size() == 0) begin
               rsp.status = ST_EMPTY;
            end else if (position < 1 || position > shadow_entries.size()) begin
               rsp.status = ST_RANGE;
            end else if (action == ACT_READ) begin
               rsp.read_value = shadow_entries[position - 1];
               got_read = 1'b1;
            end else begin
               shadow_entries.delete(position - 1);
            end
         end
      endcase
      if (!got_read) rsp.read_value = (shadow_entries.size() > 0) ? shadow_entries[0] : '0;
      rsp.count    = COUNT_WIDTH'(shadow_entries.size());
      rsp.is_empty = (shadow_entries.size() == 0);
      return rsp;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] random_entry();
      case ($urandom_range(9))
         0: return {1'b1, {(DATA_WIDTH - 1){1'b0}}};
         1: return {1'b0, {(DATA_WIDTH - 1){1'b1}}};
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] random_position();
      if (shadow_entries.size() > 0 && $urandom_range(99) < 85)
         return COUNT_WIDTH'($urandom_range(shadow_entries.size(), 1));
      return COUNT_WIDTH'($urandom_range((1 << COUNT_WIDTH) - 1, 0));
   endfunction

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic issue_request(input logic [1:0] action, input logic [DATA_WIDTH-1:0] value,
                                input logic [COUNT_WIDTH-1:0] position);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(PORT_WIDTH - DATA_WIDTH - COUNT_WIDTH){1'b0}}, position, value};
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      pending_responses.push_back(queue_outcome(action, value, position));
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      queue_response_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            $error("unexpected response: tdata %h tuser %h", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            exp_rsp = pending_responses.pop_front();
            if (rsp_tdata[DATA_WIDTH-1:0] !== exp_rsp.read_value) begin
               $error("read_value: expected %h, actual %h", exp_rsp.read_value,
                      rsp_tdata[DATA_WIDTH-1:0]);
               error_count++;
            end
            if (rsp_tdata[DATA_WIDTH +: COUNT_WIDTH] !== exp_rsp.count) begin
               $error("count: expected %0d, actual %0d", exp_rsp.count,
                      rsp_tdata[DATA_WIDTH +: COUNT_WIDTH]);
               error_count++;
            end
            if (rsp_tuser[0] !== exp_rsp.is_empty) begin
               $error("is_empty: expected %b, actual %b", exp_rsp.is_empty, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tuser[2:1] !== exp_rsp.status) begin
               $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_tuser[2:1]);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      send_idle_pct = 20;
      recv_idle_pct = 70;
      issue_request(ACT_POP, '1, 5'd1);
      issue_request(ACT_READ, '0, 5'd1);
      issue_request(ACT_REMOVE, '0, 5'd0);
      issue_request(ACT_PUSH, {1'b1, {(DATA_WIDTH - 1){1'b0}}}, 5'd31);
      issue_request(ACT_PUSH, {1'b0, {(DATA_WIDTH - 1){1'b1}}}, 5'd0);
      issue_request(ACT_PUSH, '1, 5'd16);
      issue_request(ACT_PUSH, '0, 5'd1);
      issue_request(ACT_PUSH, 32'h5a5a_a5a5, 5'd2);
      issue_request(ACT_READ, '1, 5'd0);
      issue_request(ACT_READ, '0, 5'd6);
      issue_request(ACT_READ, '0, 5'd31);
      issue_request(ACT_READ, '0, 5'd1);
      issue_request(ACT_READ, '0, 5'd5);
      issue_request(ACT_REMOVE, '0, 5'd6);
      issue_request(ACT_REMOVE, '0, 5'd2);
      issue_request(ACT_REMOVE, '0, 5'd4);
      issue_request(ACT_REMOVE, '0, 5'd1);
      issue_request(ACT_POP, '0, 5'd0);
      issue_request(ACT_POP, '0, 5'd0);
      issue_request(ACT_POP, '0, 5'd0);
      wait_for_responses();
   endtask

   task automatic test_full_queue();
      send_idle_pct = 0;
      recv_idle_pct = 20;
      repeat (DEPTH) issue_request(ACT_PUSH, random_entry(), random_position());
      issue_request(ACT_PUSH, random_entry(), 5'd0);
      issue_request(ACT_READ, random_entry(), COUNT_WIDTH'(DEPTH));
      issue_request(ACT_READ, random_entry(), COUNT_WIDTH'(DEPTH + 1));
      issue_request(ACT_REMOVE, random_entry(), 5'd31);
      issue_request(ACT_REMOVE, random_entry(), COUNT_WIDTH'(DEPTH));
      issue_request(ACT_PUSH, random_entry(), 5'd3);
      issue_request(ACT_REMOVE, random_entry(), 5'd1);
      repeat (DEPTH) issue_request(ACT_POP, random_entry(), random_position());
      wait_for_responses();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = 400;
      repeat (40) begin
         issue_request(($urandom_range(3) == 0) ? ACT_REMOVE : ACT_PUSH, random_entry(),
                       random_position());
      end
      wait_for_responses();
      repeat (20) issue_request(ACT_READ, random_entry(), random_position());
      wait_for_responses();
   endtask

   task automatic test_random_mix(input int items, input int send_pct, input int recv_pct);
      int         push_bias;
      logic [1:0] action;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      push_bias = 50;
      for (int i = 0; i < items; i++) begin
         if (i % 60 == 0) push_bias = $urandom_range(80, 20);
         if ($urandom_range(99) < push_bias) begin
            action = ACT_PUSH;
         end else begin
            case ($urandom_range(2))
               0: action = ACT_POP;
               1: action = ACT_READ;
               default: action = ACT_REMOVE;
            endcase
         end
         issue_request(action, random_entry(), random_position());
      end
      wait_for_responses();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_full_queue();
      test_backpressure();
      test_random_mix(510, 20, 70);
      test_random_mix(510, 70, 20);
      test_random_mix(510, 0, 0);
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_responses.size() != 0) begin
         $error("%0d responses never arrived", pending_responses.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_queue_with_positional_access_top passed");
      end else begin
         $display("tb_queue_with_positional_access_top failed");
      end
      $finish;
   end
endmodule
